[src/dual_controller_input_qualifier_unit_defines.svh]
// Assertion macros shared by the dual controller input qualifier sources.
`ifndef DUAL_CONTROLLER_INPUT_QUALIFIER_UNIT_DEFINES_SVH
`define DUAL_CONTROLLER_INPUT_QUALIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DCQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define DCQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/dcq_pkg.sv]
// Types and constants for the dual controller input qualifier.
package dcq_pkg;

   localparam int unsigned LEVEL_W = 15;
   localparam int unsigned AXIS_W  = 16;
   localparam int unsigned CSR_AW  = 5;
   localparam int unsigned CSR_DW  = 32;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic signed [AXIS_W-1:0] axis_type;

   // register map, byte address = 4 * index
   typedef enum logic [2:0] {
      CSR_STICK_ON  = 3'd0,
      CSR_STICK_OFF = 3'd1,
      CSR_GRIP_ON   = 3'd2,
      CSR_GRIP_OFF  = 3'd3,
      CSR_RECALL    = 3'd4,
      CSR_SHOULDER  = 3'd5
   } csr_index_type;

   localparam level_type STICK_ON_RST  = 15'd18022;
   localparam level_type STICK_OFF_RST = 15'd11469;
   localparam level_type GRIP_ON_RST   = 15'd19661;
   localparam level_type GRIP_OFF_RST  = 15'd11469;
   localparam level_type RECALL_RST    = 15'd22938;
   localparam level_type SHOULDER_RST  = 15'd16384;

   // bit0 up, bit1 down, bit2 left, bit3 right
   typedef struct packed {
      logic right;
      logic left;
      logic down;
      logic up;
   } dpad_type;

   typedef struct packed {
      level_type stick_set;
      level_type stick_clear;
      level_type grip_set;
      level_type grip_clear;
      level_type recall;
      level_type shoulder;
   } levels_type;

   typedef struct packed {
      dpad_type   dpad;
      logic       button_a;
      logic       button_b;
      logic       shoulder_left;
      logic       shoulder_right;
      logic       menu_pressed;
      logic [1:0] grab_count;
      logic       holding_hand;
      logic       recall_pulse;
   } result_type;

endpackage

[src/dcq_stick_lane.sv]
// One stick lane: hysteresis on both axes, starting from the shared d-pad latch.
module dcq_stick_lane
   import dcq_pkg::*;
(
   input  axis_type  axis_x,
   input  axis_type  axis_y,
   input  dpad_type  latch,
   input  level_type on_level,
   input  level_type off_level,
   output dpad_type  dpad_next
);

   logic signed [AXIS_W:0] on_ext;
   logic signed [AXIS_W:0] off_ext;
   logic [1:0] x_step;
   logic [1:0] y_step;

   // returns {neg, pos}
   function automatic logic [1:0] axis_step(
      input logic signed [AXIS_W:0] v,
      input logic neg,
      input logic pos,
      input logic signed [AXIS_W:0] on_l,
      input logic signed [AXIS_W:0] off_l
   );
      logic neg_n;
      logic pos_n;
      pos_n = pos ? !(v < off_l) : (v > on_l);
      neg_n = neg ? !(v > -off_l) : (v < -on_l);
      return {neg_n, pos_n};
   endfunction

   assign on_ext  = {2'b00, on_level};
   assign off_ext = {2'b00, off_level};

   assign x_step = axis_step({axis_x[AXIS_W-1], axis_x}, latch.left, latch.right,
                             on_ext, off_ext);
   assign y_step = axis_step({axis_y[AXIS_W-1], axis_y}, latch.down, latch.up,
                             on_ext, off_ext);

   assign dpad_next.left  = x_step[1];
   assign dpad_next.right = x_step[0];
   assign dpad_next.down  = y_step[1];
   assign dpad_next.up    = y_step[0];

endmodule

[src/dcq_grip_lane.sv]
// One grip lane: latch on high bar, release on low bar or loss of tracking.
module dcq_grip_lane
   import dcq_pkg::*;
(
   input  logic      tracked,
   input  level_type squeeze,
   input  logic      held,
   input  level_type on_level,
   input  level_type off_level,
   output logic      held_next
);

   always_comb begin
      if (!tracked) begin
         held_next = 1'b0;
      end else if (held) begin
         held_next = !(squeeze < off_level);
      end else begin
         held_next = squeeze > on_level;
      end
   end

endmodule

[src/dcq_merge.sv]
// Merge stage: combines lane outcomes into one result and the next hand state.
module dcq_merge
   import dcq_pkg::*;
(
   input  dpad_type   left_dpad,
   input  dpad_type   right_dpad,
   input  logic [1:0] grip_next,
   input  logic       last_hand,
   input  level_type  left_trigger,
   input  level_type  right_trigger,
   input  logic [4:0] button_bits,
   input  levels_type levels,
   output logic       last_hand_next,
   output result_type result
);

   logic [1:0] grab;

   assign grab = {1'b0, grip_next[0]} + {1'b0, grip_next[1]};
   // single grab picks the hand; otherwise keep the last one
   assign last_hand_next = (grab == 2'd1) ? grip_next[1] : last_hand;

   always_comb begin
      result.dpad           = left_dpad | right_dpad;
      result.button_a       = button_bits[0] | button_bits[2];
      result.button_b       = button_bits[1] | button_bits[3];
      result.shoulder_left  = (grab != 2'd2) && (left_trigger > levels.shoulder);
      result.shoulder_right = (grab != 2'd2) && (right_trigger > levels.shoulder);
      result.menu_pressed   = button_bits[4];
      result.grab_count     = grab;
      result.holding_hand   = last_hand_next;
      result.recall_pulse   = (grab == 2'd2) && (left_trigger > levels.recall)
                              && (right_trigger > levels.recall);
   end

endmodule

[src/dual_controller_input_qualifier_unit.sv]
// Top level of the dual controller input qualifier.
//
// Usage: each request on the req_ channel is one frame from two hand
// controllers (four stick axes in Q1.15, two squeeze and two trigger levels
// in unsigned Q0.15, tracking and button bits). Each accepted request yields
// exactly one response on the rsp_ channel: latched d-pad, face buttons,
// shoulders, menu, grab count, holding hand and recall pulse.
// Output: each result is registered in the response or the skid register.
// Throughput: one request per cycle while req_ready is high; all comparators
// of both stick lanes, both grip lanes and the merge stage are combinational
// and the state latches update on each accepted request.
// Stall: a two-entry output (response register plus skid register) lets one
// more request in while a response waits; req_ready drops only when both are
// full, and rises again once the receiver takes a response.
// Reset (synchronous, active high): d-pad and grip latches clear, holding
// hand returns to left, thresholds go to their defaults, both output entries
// empty. Thresholds go over the csr_ APB port, 4 bytes apart; the user must
// write them only while no request is in flight, not enforced by the block.
`include "dual_controller_input_qualifier_unit_defines.svh"

module dual_controller_input_qualifier_unit
   import dcq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  axis_type          req_left_stick_x,
   input  axis_type          req_left_stick_y,
   input  axis_type          req_right_stick_x,
   input  axis_type          req_right_stick_y,
   input  level_type         req_left_squeeze,
   input  level_type         req_right_squeeze,
   input  level_type         req_left_trigger,
   input  level_type         req_right_trigger,
   input  logic [1:0]        req_tracked_mask,
   input  logic [4:0]        req_button_bits,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_dpad_up,
   output logic              rsp_dpad_down,
   output logic              rsp_dpad_left,
   output logic              rsp_dpad_right,
   output logic              rsp_button_a,
   output logic              rsp_button_b,
   output logic              rsp_shoulder_left,
   output logic              rsp_shoulder_right,
   output logic              rsp_menu_pressed,
   output logic [1:0]        rsp_grab_count,
   output logic              rsp_holding_hand,
   output logic              rsp_recall_pulse,
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   levels_type    levels_ff;
   dpad_type      dpad_ff;
   logic [1:0]    grip_ff;
   logic          hand_ff;
   result_type    out_ff;
   logic          out_valid_ff;
   result_type    skid_ff;
   logic          skid_valid_ff;

   levels_type    levels_in;
   csr_index_type csr_index;
   logic          csr_write;
   logic          accept;
   dpad_type      left_dpad;
   dpad_type      right_dpad;
   logic [1:0]    grip_in;
   logic          hand_in;
   result_type    result;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      levels_in = levels_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_STICK_ON:  levels_in.stick_set   = csr_pwdata[LEVEL_W-1:0];
            CSR_STICK_OFF: levels_in.stick_clear = csr_pwdata[LEVEL_W-1:0];
            CSR_GRIP_ON:   levels_in.grip_set    = csr_pwdata[LEVEL_W-1:0];
            CSR_GRIP_OFF:  levels_in.grip_clear  = csr_pwdata[LEVEL_W-1:0];
            CSR_RECALL:    levels_in.recall      = csr_pwdata[LEVEL_W-1:0];
            CSR_SHOULDER:  levels_in.shoulder    = csr_pwdata[LEVEL_W-1:0];
            default:       levels_in = levels_ff;  // beyond the map: ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_STICK_ON:  csr_prdata = CSR_DW'(levels_ff.stick_set);
         CSR_STICK_OFF: csr_prdata = CSR_DW'(levels_ff.stick_clear);
         CSR_GRIP_ON:   csr_prdata = CSR_DW'(levels_ff.grip_set);
         CSR_GRIP_OFF:  csr_prdata = CSR_DW'(levels_ff.grip_clear);
         CSR_RECALL:    csr_prdata = CSR_DW'(levels_ff.recall);
         CSR_SHOULDER:  csr_prdata = CSR_DW'(levels_ff.shoulder);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- lanes ----------------
   // both stick lanes start from the same latch; merge ORs their outcomes
   dcq_stick_lane u_stick_left (
      .axis_x    (req_left_stick_x),
      .axis_y    (req_left_stick_y),
      .latch     (dpad_ff),
      .on_level  (levels_ff.stick_set),
      .off_level (levels_ff.stick_clear),
      .dpad_next (left_dpad)
   );

   dcq_stick_lane u_stick_right (
      .axis_x    (req_right_stick_x),
      .axis_y    (req_right_stick_y),
      .latch     (dpad_ff),
      .on_level  (levels_ff.stick_set),
      .off_level (levels_ff.stick_clear),
      .dpad_next (right_dpad)
   );

   dcq_grip_lane u_grip_left (
      .tracked   (req_tracked_mask[0]),
      .squeeze   (req_left_squeeze),
      .held      (grip_ff[0]),
      .on_level  (levels_ff.grip_set),
      .off_level (levels_ff.grip_clear),
      .held_next (grip_in[0])
   );

   dcq_grip_lane u_grip_right (
      .tracked   (req_tracked_mask[1]),
      .squeeze   (req_right_squeeze),
      .held      (grip_ff[1]),
      .on_level  (levels_ff.grip_set),
      .off_level (levels_ff.grip_clear),
      .held_next (grip_in[1])
   );

   dcq_merge u_merge (
      .left_dpad      (left_dpad),
      .right_dpad     (right_dpad),
      .grip_next      (grip_in),
      .last_hand      (hand_ff),
      .left_trigger   (req_left_trigger),
      .right_trigger  (req_right_trigger),
      .button_bits    (req_button_bits),
      .levels         (levels_ff),
      .last_hand_next (hand_in),
      .result         (result)
   );

   // ---------------- handshake and state ----------------
   // skid register full is the only thing that holds off a request
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff     <= '{stick_set: STICK_ON_RST,  stick_clear: STICK_OFF_RST,
                            grip_set:  GRIP_ON_RST,   grip_clear:  GRIP_OFF_RST,
                            recall:    RECALL_RST,    shoulder:    SHOULDER_RST};
         dpad_ff       <= '0;
         grip_ff       <= '0;
         hand_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         levels_ff <= levels_in;
         if (accept) begin
            dpad_ff <= result.dpad;
            grip_ff <= grip_in;
            hand_ff <= hand_in;
         end
         if (!out_valid_ff || rsp_ready) begin
            if (skid_valid_ff) begin
               // skid full means no request this cycle
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_dpad_up        = out_ff.dpad.up;
   assign rsp_dpad_down      = out_ff.dpad.down;
   assign rsp_dpad_left      = out_ff.dpad.left;
   assign rsp_dpad_right     = out_ff.dpad.right;
   assign rsp_button_a       = out_ff.button_a;
   assign rsp_button_b       = out_ff.button_b;
   assign rsp_shoulder_left  = out_ff.shoulder_left;
   assign rsp_shoulder_right = out_ff.shoulder_right;
   assign rsp_menu_pressed   = out_ff.menu_pressed;
   assign rsp_grab_count     = out_ff.grab_count;
   assign rsp_holding_hand   = out_ff.holding_hand;
   assign rsp_recall_pulse   = out_ff.recall_pulse;

   // ---------------- assertions ----------------
   `DCQ_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full with output empty")
   `DCQ_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_ready, !skid_valid_ff, "skid not drained")
   `DCQ_ASSERT_NEXT(a_untracked_left, accept && !req_tracked_mask[0], !grip_ff[0], "untracked grip")
   `DCQ_ASSERT_NOW(a_recall_both, rsp_valid && rsp_recall_pulse, rsp_grab_count == 2'd2, "lone recall")
   `DCQ_ASSERT_NOW(a_shoulder_off, rsp_valid && rsp_grab_count == 2'd2, !rsp_shoulder_left && !rsp_shoulder_right, "shoulder on")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench for the dual controller input qualifier: random and directed frames, checked against a predictor.
module tb
   import dcq_pkg::*;
();

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          REPORT_LIMIT  = 30;
   localparam int          HOLD_SPACING  = 400;
   // indexes past the register map; writes there must change nothing
   localparam int unsigned UNMAPPED_LOW  = 6;
   localparam int unsigned UNMAPPED_HIGH = 7;
   localparam int          LEVEL_MAX     = 32767;
   localparam int          AXIS_MIN      = -32768;

   // one frame from both hands, as carried by a request
   typedef struct {
      axis_type   left_stick_x;
      axis_type   left_stick_y;
      axis_type   right_stick_x;
      axis_type   right_stick_y;
      level_type  left_squeeze;
      level_type  right_squeeze;
      level_type  left_trigger;
      level_type  right_trigger;
      logic [1:0] tracked_mask;
      logic [4:0] button_bits;
   } frame_type;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid          = 1'b0;
   logic              req_ready;
   axis_type          req_left_stick_x   = '0;
   axis_type          req_left_stick_y   = '0;
   axis_type          req_right_stick_x  = '0;
   axis_type          req_right_stick_y  = '0;
   level_type         req_left_squeeze   = '0;
   level_type         req_right_squeeze  = '0;
   level_type         req_left_trigger   = '0;
   level_type         req_right_trigger  = '0;
   logic [1:0]        req_tracked_mask   = '0;
   logic [4:0]        req_button_bits    = '0;

   logic              rsp_valid;
   logic              rsp_ready          = 1'b0;
   logic              rsp_dpad_up;
   logic              rsp_dpad_down;
   logic              rsp_dpad_left;
   logic              rsp_dpad_right;
   logic              rsp_button_a;
   logic              rsp_button_b;
   logic              rsp_shoulder_left;
   logic              rsp_shoulder_right;
   logic              rsp_menu_pressed;
   logic [1:0]        rsp_grab_count;
   logic              rsp_holding_hand;
   logic              rsp_recall_pulse;

   logic              csr_psel           = 1'b0;
   logic              csr_penable        = 1'b0;
   logic              csr_pwrite         = 1'b0;
   logic [CSR_AW-1:0] csr_paddr          = '0;
   logic [CSR_DW-1:0] csr_pwdata         = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   dual_controller_input_qualifier_unit i_dut (.*);

   // ---------------------------------------------------------------------
   // Shadow of the block: thresholds as last written, plus the latches.
   // All of it starts at its reset value; reset is applied only once.
   // ---------------------------------------------------------------------
   levels_type lvl = '{stick_set: STICK_ON_RST,  stick_clear: STICK_OFF_RST,
                       grip_set:  GRIP_ON_RST,   grip_clear:  GRIP_OFF_RST,
                       recall:    RECALL_RST,    shoulder:    SHOULDER_RST};
   dpad_type   dpad_held   = '0;
   logic [1:0] grip_held   = '0;
   logic       single_hand = 1'b0;

   frame_type  pending_frames[$];
   result_type predicted_outputs[$];

   int  frames_queued   = 0;
   int  accepted_count  = 0;
   int  results_checked = 0;
   int  mismatch_count  = 0;
   int  cycle_count     = 0;
   logic req_fire       = 1'b0;

   // sender burst shaping
   int  burst_left = 1;
   int  gap_left   = 0;

   // receiver stall shaping
   int          hold_left    = 0;
   int          next_hold_at = 150;
   int          stall_mode   = 0;
   int          mode_left    = 0;
   logic [15:0] stall_pattern = 16'h00ff;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Hysteresis on one axis, returns {positive, negative} latch.
   // Positive releases when v drops below off, negative when v rises above -off;
   // the levels are used as written, even with off above on.
   function automatic logic [1:0] axis_hysteresis(input int v, input logic neg_held,
                                                  input logic pos_held);
      int   on_l;
      int   off_l;
      logic pos;
      logic neg;
      on_l  = int'(lvl.stick_set);
      off_l = int'(lvl.stick_clear);
      pos   = pos_held ? !(v < off_l) : (v > on_l);
      neg   = neg_held ? !(v > -off_l) : (v < -on_l);
      return {pos, neg};
   endfunction

   // Advances the shadow latches by one frame and gives the response it must cause.
   function automatic result_type qualify_frame(input frame_type f);
      result_type r;
      level_type  squeeze[2];
      logic [1:0] lh;
      logic [1:0] lv;
      logic [1:0] rh;
      logic [1:0] rv;
      int         grabs;
      squeeze[0] = f.left_squeeze;
      squeeze[1] = f.right_squeeze;
      // an untracked hand lets go at once, whatever its squeeze
      for (int i = 0; i < 2; i++) begin
         if (!f.tracked_mask[i]) begin
            grip_held[i] = 1'b0;
         end else if (grip_held[i]) begin
            if (squeeze[i] < lvl.grip_clear) grip_held[i] = 1'b0;
         end else if (squeeze[i] > lvl.grip_set) begin
            grip_held[i] = 1'b1;
         end
      end
      grabs = int'(grip_held[0]) + int'(grip_held[1]);
      // holding hand only moves on a single-hand grab
      if (grabs == 1) single_hand = grip_held[1];

      // both sticks start from the same latched d-pad; the new latch is their OR
      lh = axis_hysteresis(int'(f.left_stick_x),  dpad_held.left, dpad_held.right);
      lv = axis_hysteresis(int'(f.left_stick_y),  dpad_held.down, dpad_held.up);
      rh = axis_hysteresis(int'(f.right_stick_x), dpad_held.left, dpad_held.right);
      rv = axis_hysteresis(int'(f.right_stick_y), dpad_held.down, dpad_held.up);
      dpad_held.right = lh[1] | rh[1];
      dpad_held.left  = lh[0] | rh[0];
      dpad_held.up    = lv[1] | rv[1];
      dpad_held.down  = lv[0] | rv[0];

      r.dpad           = dpad_held;
      r.button_a       = f.button_bits[0] | f.button_bits[2];
      r.button_b       = f.button_bits[1] | f.button_bits[3];
      r.shoulder_left  = (grabs < 2) && (f.left_trigger > lvl.shoulder);
      r.shoulder_right = (grabs < 2) && (f.right_trigger > lvl.shoulder);
      r.menu_pressed   = f.button_bits[4];
      r.grab_count     = 2'(grabs);
      r.holding_hand   = single_hand;
      r.recall_pulse   = (grabs == 2) && (f.left_trigger > lvl.recall)
                         && (f.right_trigger > lvl.recall);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic frame_type frame_of(input int lx, input int ly, input int rx,
                                          input int ry, input int lsq, input int rsq,
                                          input int lt, input int rt, input int trk,
                                          input int btn);
      frame_type f;
      f.left_stick_x  = axis_type'(lx);
      f.left_stick_y  = axis_type'(ly);
      f.right_stick_x = axis_type'(rx);
      f.right_stick_y = axis_type'(ry);
      f.left_squeeze  = level_type'(lsq);
      f.right_squeeze = level_type'(rsq);
      f.left_trigger  = level_type'(lt);
      f.right_trigger = level_type'(rt);
      f.tracked_mask  = 2'(trk);
      f.button_bits   = 5'(btn);
      return f;
   endfunction

   // A level that lands on or right next to one of two thresholds most of the time,
   // so the hysteresis edges are hit with the current settings.
   function automatic level_type near_level(input level_type a, input level_type b);
      int v;
      case ($urandom_range(0, 9))
         0: v = int'(a) - 1;
         1: v = int'(a);
         2: v = int'(a) + 1;
         3: v = int'(b) - 1;
         4: v = int'(b);
         5: v = int'(b) + 1;
         6: v = $urandom_range(int'(a), int'(b));
         7: v = 0;
         8: v = LEVEL_MAX;
         default: v = $urandom_range(0, LEVEL_MAX);
      endcase
      if (v < 0) v = 0;
      if (v > LEVEL_MAX) v = LEVEL_MAX;
      return level_type'(v);
   endfunction

   function automatic axis_type random_axis();
      int v;
      if ($urandom_range(0, 3) == 0) begin
         v = $urandom_range(0, 2000) - 1000;
      end else begin
         v = int'(near_level(lvl.stick_set, lvl.stick_clear));
         if ($urandom_range(0, 1)) v = -v;
         if ($urandom_range(0, 15) == 0) v = AXIS_MIN;
      end
      return axis_type'(v);
   endfunction

   // Mostly plausible frames around the thresholds, hands tracked; the rest is noise.
   function automatic frame_type random_frame();
      frame_type f;
      if ($urandom_range(0, 4) == 0) begin
         f = frame_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      end else begin
         f.left_stick_x  = random_axis();
         f.left_stick_y  = random_axis();
         f.right_stick_x = random_axis();
         f.right_stick_y = random_axis();
         f.left_squeeze  = near_level(lvl.grip_set, lvl.grip_clear);
         f.right_squeeze = near_level(lvl.grip_set, lvl.grip_clear);
         f.left_trigger  = near_level(lvl.recall, lvl.shoulder);
         f.right_trigger = near_level(lvl.recall, lvl.shoulder);
         f.tracked_mask  = ($urandom_range(0, 6) != 0) ? 2'b11 : 2'($urandom);
         f.button_bits   = 5'($urandom);
      end
      return f;
   endfunction

   task automatic queue_frame(input frame_type f);
      pending_frames.push_back(f);
      frames_queued++;
   endtask

   // Idle means every queued request accepted and every response checked.
   // The counters move at the rising edge, so they are read at the falling one.
   task automatic wait_idle();
      while (accepted_count != frames_queued || results_checked != accepted_count)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // APB write: setup, then access until pready; the shadow follows at the write edge.
   task automatic csr_write(input int unsigned idx, input level_type value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(idx * 4);
      // junk in the upper bits: only the low 15 are kept
      csr_pwdata  <= ($urandom & ~32'h7fff) | CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_STICK_ON:  lvl.stick_set   = value;
         CSR_STICK_OFF: lvl.stick_clear = value;
         CSR_GRIP_ON:   lvl.grip_set    = value;
         CSR_GRIP_OFF:  lvl.grip_clear  = value;
         CSR_RECALL:    lvl.recall      = value;
         CSR_SHOULDER:  lvl.shoulder    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_levels(input int so, input int sf, input int go, input int gf,
                             input int rc, input int sh);
      csr_write(CSR_STICK_ON,  level_type'(so));
      csr_write(CSR_STICK_OFF, level_type'(sf));
      csr_write(CSR_GRIP_ON,   level_type'(go));
      csr_write(CSR_GRIP_OFF,  level_type'(gf));
      csr_write(CSR_RECALL,    level_type'(rc));
      csr_write(CSR_SHOULDER,  level_type'(sh));
   endtask

   task automatic random_phase(input int n);
      repeat (n) queue_frame(random_frame());
      wait_idle();
   endtask

   task automatic check_field(input string name, input logic [1:0] want,
                              input logic [1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------------
   // Clock and run limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps in between.
   // A request stays put until req_fire says it went in at the last edge.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      frame_type f;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // still waiting for acceptance: hold valid and payload
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pending_frames.size() != 0) begin
         f = pending_frames.pop_front();
         req_left_stick_x  <= f.left_stick_x;
         req_left_stick_y  <= f.left_stick_y;
         req_right_stick_x <= f.right_stick_x;
         req_right_stick_y <= f.right_stick_y;
         req_left_squeeze  <= f.left_squeeze;
         req_right_squeeze <= f.right_squeeze;
         req_left_trigger  <= f.left_trigger;
         req_right_trigger <= f.right_trigger;
         req_tracked_mask  <= f.tracked_mask;
         req_button_bits   <= f.button_bits;
         req_valid         <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // a quarter of bursts run straight into the next one
            case ($urandom_range(0, 7))
               0, 1:    gap_left <= 0;
               2:       gap_left <= $urandom_range(9, 20);
               default: gap_left <= $urandom_range(1, 4);
            endcase
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Request side monitor: predict at the edge the request goes in.
   always @(posedge clock) begin : take_requests
      frame_type seen;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         seen.left_stick_x  = req_left_stick_x;
         seen.left_stick_y  = req_left_stick_y;
         seen.right_stick_x = req_right_stick_x;
         seen.right_stick_y = req_right_stick_y;
         seen.left_squeeze  = req_left_squeeze;
         seen.right_squeeze = req_right_squeeze;
         seen.left_trigger  = req_left_trigger;
         seen.right_trigger = req_right_trigger;
         seen.tracked_mask  = req_tracked_mask;
         seen.button_bits   = req_button_bits;
         predicted_outputs.push_back(qualify_frame(seen));
         accepted_count++;
      end
   end

   // ---------------------------------------------------------------------
   // Response receiver: changing stall patterns, plus a long hold-off every
   // few hundred requests so the skid buffer fills and req_ready drops.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (accepted_count >= next_hold_at) begin
         rsp_ready    <= 1'b0;
         hold_left    <= $urandom_range(40, 80);
         next_hold_at <= next_hold_at + HOLD_SPACING;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_ready     <= stall_pattern[0];
               stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
         endcase
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 200);
            if (stall_mode != 3) stall_pattern <= 16'($urandom) | 16'h0001;
         end else begin
            mode_left <= mode_left - 1;
         end
      end
   end

   // Response monitor: oldest prediction first, field by field.
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outputs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: response with no request outstanding", $time);
         end else begin
            want = predicted_outputs.pop_front();
            results_checked++;
            check_field("dpad_up",        want.dpad.up,         rsp_dpad_up);
            check_field("dpad_down",      want.dpad.down,       rsp_dpad_down);
            check_field("dpad_left",      want.dpad.left,       rsp_dpad_left);
            check_field("dpad_right",     want.dpad.right,      rsp_dpad_right);
            check_field("button_a",       want.button_a,        rsp_button_a);
            check_field("button_b",       want.button_b,        rsp_button_b);
            check_field("shoulder_left",  want.shoulder_left,   rsp_shoulder_left);
            check_field("shoulder_right", want.shoulder_right,  rsp_shoulder_right);
            check_field("menu_pressed",   want.menu_pressed,    rsp_menu_pressed);
            check_field("grab_count",     want.grab_count,      rsp_grab_count);
            check_field("holding_hand",   want.holding_hand,    rsp_holding_hand);
            check_field("recall_pulse",   want.recall_pulse,    rsp_recall_pulse);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence: directed frames at reset levels, then random phases with
   // new thresholds written between them while nothing is in flight.
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // face buttons, one at a time, then all
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 3, 0));
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 3, 1));
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 3, 2));
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 3, 4));
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 3, 8));
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 3, 16));
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 3, 31));
      // stick extremes: right latches, then swings to full left
      queue_frame(frame_of(LEVEL_MAX, 0, 0, 0, 0, 0, 0, 0, 3, 0));
      queue_frame(frame_of(AXIS_MIN, 0, 0, 0, 0, 0, 0, 0, 3, 0));
      queue_frame(frame_of(AXIS_MIN, LEVEL_MAX, 0, AXIS_MIN, 0, 0, 0, 0, 3, 0));
      // sitting exactly on the off level keeps left held
      queue_frame(frame_of(-int'(STICK_OFF_RST), LEVEL_MAX, 0, 0, 0, 0, 0, 0, 3, 0));
      // both sticks, one latch: left lets go of up, right keeps it
      queue_frame(frame_of(0, 0, 0, LEVEL_MAX, 0, 0, 0, 0, 3, 0));
      // both grips, triggers high: recall, shoulders suppressed
      queue_frame(frame_of(0, 0, 0, 0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 3, 0));
      queue_frame(frame_of(0, 0, 0, 0, GRIP_OFF_RST, GRIP_OFF_RST, 0, 0, 3, 0));
      queue_frame(frame_of(0, 0, 0, 0, 0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 3, 0));
      // right hand lost with full squeeze: released, left grabs and becomes the holding hand
      queue_frame(frame_of(0, 0, 0, 0, LEVEL_MAX, LEVEL_MAX, 0, 0, 1, 0));
      queue_frame(frame_of(0, 0, 0, 0, LEVEL_MAX, LEVEL_MAX, 0, 0, 2, 0));
      queue_frame(frame_of(0, 0, 0, 0, LEVEL_MAX, LEVEL_MAX, 0, 0, 0, 0));
      queue_frame(frame_of(0, 0, 0, 0, LEVEL_MAX, 0, 0, 0, 3, 0));
      // both grips, triggers exactly on the recall level: no pulse
      queue_frame(frame_of(0, 0, 0, 0, LEVEL_MAX, LEVEL_MAX, RECALL_RST, RECALL_RST, 3, 0));
      queue_frame(frame_of(0, 0, 0, 0, LEVEL_MAX, LEVEL_MAX, RECALL_RST + 1, RECALL_RST + 1,
                           3, 0));
      // shoulders at and just past their level
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, SHOULDER_RST, SHOULDER_RST, 3, 0));
      queue_frame(frame_of(0, 0, 0, 0, 0, 0, SHOULDER_RST + 1, SHOULDER_RST + 1, 3, 0));
      queue_frame(frame_of(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 0, 0, 0, 0, 3, 0));
      queue_frame(frame_of(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 0, 0, 0, 0, 3, 0));
      random_phase(300);

      // random thresholds; writes past the map must leave them alone
      set_levels($urandom_range(0, LEVEL_MAX), $urandom_range(0, LEVEL_MAX),
                 $urandom_range(0, LEVEL_MAX), $urandom_range(0, LEVEL_MAX),
                 $urandom_range(0, LEVEL_MAX), $urandom_range(0, LEVEL_MAX));
      csr_write(UNMAPPED_LOW, level_type'($urandom));
      csr_write(UNMAPPED_HIGH, level_type'($urandom));
      random_phase(300);

      // all levels at the bottom
      set_levels(0, 0, 0, 0, 0, 0);
      random_phase(250);

      // all levels at the top: only the most negative axis can latch
      set_levels(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
      random_phase(250);

      // off levels above on levels, taken as they stand
      set_levels(6000, 28000, 7000, 26000, 12000, 9000);
      random_phase(300);

      // close together, small values
      set_levels($urandom_range(0, 4000), $urandom_range(0, 4000),
                 $urandom_range(0, 4000), $urandom_range(0, 4000),
                 $urandom_range(0, 4000), $urandom_range(0, 4000));
      random_phase(300);

      // back to the reset levels
      set_levels(STICK_ON_RST, STICK_OFF_RST, GRIP_ON_RST, GRIP_OFF_RST, RECALL_RST,
                 SHOULDER_RST);
      random_phase(200);

      // drain and let any stray response from the pipeline show before the verdict
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
